/* rtl/spq_pkg.sv */
// types and constants shared by the sorted priority queue
// no dependencies
package spq_pkg;

   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] item_id;
      logic [15:0] produce_time;
      logic [15:0] consume_time;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        out_item_id;
      logic [15:0]        out_produce_time;
      logic [15:0]        out_consume_time;
      logic [7:0]         out_priority;
      logic [COUNT_W-1:0] entry_count_after;
   } rsp_type;

   typedef struct packed {
      logic [15:0] item_id;
      logic [15:0] produce_time;
      logic [15:0] consume_time;
      logic [7:0]  prio;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift_in;
      logic shift_out;
   } cell_ctl_type;

endpackage

/* rtl/spq_cell.sv */
// one slot of the sorted row: holds an entry, shifts right on insert, left on remove
// depends on spq_pkg
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::entry_type   new_entry,
   input  logic                 occupied,
   input  logic                 left_gt,
   input  spq_pkg::entry_type   left_entry,
   input  spq_pkg::entry_type   right_entry,
   output logic                 gt,
   output spq_pkg::entry_type   entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // empty slots count as greater, so the first greater slot is the insert point
   assign gt    = !occupied || (entry_ff.prio > new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_in) begin
         if (gt) begin
            entry_in = left_gt ? left_entry : new_entry;
         end
      end else if (ctl.shift_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/sorted_priority_queue.sv */
// the result of an accepted item is registered and appears on rsp_valid in the next cycle
// throughput: one item per cycle while the result side keeps taking items
// every cell decides its own move from its neighbor's compare, so an insert or
// remove finishes in the cycle it is accepted whatever the queue depth
// reset: count cleared, capacity set to 64, no result pending; entries are not cleared
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  spq_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output spq_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [spq_pkg::COUNT_W-1:0]  csr_wdata
);
   import spq_pkg::*;

   localparam int DEPTH_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LIM_W   = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   logic [COUNT_W-1:0] capacity_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   logic               accept;
   logic               is_insert;
   logic               full;
   logic               empty;
   logic [LIM_W-1:0]   cap_ext;
   logic [LIM_W-1:0]   limit;
   cell_ctl_type       ctl;
   entry_type          new_entry;

   entry_type          cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_gt;
   logic [QUEUE_DEPTH-1:0] cell_occ;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept    = req_valid && req_ready;
   assign is_insert = (req_data.opcode == OP_INSERT);

   assign cap_ext = LIM_W'(capacity_ff);
   assign limit   = (cap_ext > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH) : cap_ext;
   assign full    = LIM_W'(count_ff) >= limit;
   assign empty   = (count_ff == '0);

   assign ctl.shift_in  = accept && is_insert && !full;
   assign ctl.shift_out = accept && !is_insert && !empty;

   assign new_entry.item_id      = req_data.item_id;
   assign new_entry.produce_time = req_data.produce_time;
   assign new_entry.consume_time = req_data.consume_time;
   assign new_entry.prio         = req_data.priority_req;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         // slots past what the count can reach stay empty
         if (i < COUNT_MAX) begin : g_occ
            assign cell_occ[i] = count_ff > COUNT_W'(i);
         end else begin : g_never
            assign cell_occ[i] = 1'b0;
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .occupied    (cell_occ[i]),
            .left_gt     ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .gt          (cell_gt[i]),
            .entry       (cell_entry[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.shift_in) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.shift_out) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      rsp_data_in                   = '0;
      rsp_data_in.status            = STATUS_DONE;
      rsp_data_in.entry_count_after = count_in;
      if (is_insert) begin
         if (full) begin
            rsp_data_in.status = STATUS_FULL;
         end
      end else if (empty) begin
         rsp_data_in.status = STATUS_EMPTY;
      end else begin
         rsp_data_in.out_item_id      = cell_entry[0].item_id;
         rsp_data_in.out_produce_time = cell_entry[0].produce_time;
         rsp_data_in.out_consume_time = cell_entry[0].consume_time;
         rsp_data_in.out_priority     = cell_entry[0].prio;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/spq_checker.sv */
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue
module spq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input spq_pkg::rsp_type             rsp_data
);
   import spq_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input side never waits on a free output slot
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("item refused with output slot free");

   // refused operations carry no item
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |->
         rsp_data.out_item_id == '0 && rsp_data.out_produce_time == '0 &&
         rsp_data.out_consume_time == '0 && rsp_data.out_priority == '0)
      else $error("refused item carries data");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.entry_count_after == '0)
      else $error("empty status with entries stored");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
